// File: src/assert_macros.svh
// Assertion macros shared by the start-light detector RTL.
// No dependencies; included by every module that carries assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Clocked property that is switched off while reset is high.
`define SLPD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked property that is also checked during reset.
`define SLPD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SLPD_ASSERT(label, clk, rst, prop, msg)
`define SLPD_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// File: src/slpd_pkg.sv
// Shared types and constants for the start-light pattern detector.
// No dependencies; imported by all detector modules.
`default_nettype none
package slpd_pkg;

   localparam int TimeWidth  = 32;
   localparam int ShortWidth = 16;
   localparam int StateWidth = 2;
   localparam int IndexWidth = 3;
   localparam int DataWidth  = 32;

   // Detector state codes.
   localparam logic [StateWidth-1:0] ST_UNKNOWN = 2'd0;
   localparam logic [StateWidth-1:0] ST_IDLE    = 2'd1;
   localparam logic [StateWidth-1:0] ST_READY   = 2'd2;
   localparam logic [StateWidth-1:0] ST_START   = 2'd3;

   // Configuration register indexes.
   localparam logic [IndexWidth-1:0] REG_PULSE_MIN     = 3'd0;
   localparam logic [IndexWidth-1:0] REG_PULSE_MAX     = 3'd1;
   localparam logic [IndexWidth-1:0] REG_GAP_TIMEOUT   = 3'd2;
   localparam logic [IndexWidth-1:0] REG_SETTLE_WINDOW = 3'd3;
   localparam logic [IndexWidth-1:0] REG_READY_HOLD    = 3'd4;
   localparam logic [IndexWidth-1:0] REG_READY_TIMEOUT = 3'd5;

   // Reset values of the configuration registers.
   localparam logic [ShortWidth-1:0] RST_PULSE_MIN     = 16'd40;
   localparam logic [ShortWidth-1:0] RST_PULSE_MAX     = 16'd60;
   localparam logic [ShortWidth-1:0] RST_GAP_TIMEOUT   = 16'd120;
   localparam logic [ShortWidth-1:0] RST_SETTLE_WINDOW = 16'd500;
   localparam logic [ShortWidth-1:0] RST_READY_HOLD    = 16'd2000;
   localparam logic [TimeWidth-1:0]  RST_READY_TIMEOUT = 32'd300000;

   typedef struct packed {
      logic [ShortWidth-1:0] pulse_min_ms;
      logic [ShortWidth-1:0] pulse_max_ms;
      logic [ShortWidth-1:0] gap_timeout_ms;
      logic [ShortWidth-1:0] settle_window_ms;
      logic [ShortWidth-1:0] ready_hold_ms;
      logic [TimeWidth-1:0]  ready_timeout_ms;
   } cfg_type;

   typedef struct packed {
      logic [StateWidth-1:0] detector_state;
      logic [StateWidth-1:0] prior_state;
      logic                  state_changed;
   } result_type;

endpackage
`default_nettype wire

// File: src/slpd_csr.sv
// Configuration register file of the start-light detector.
// Depends on slpd_pkg for the register layout, indexes and reset values.
`default_nettype none
module slpd_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_write_enable,
   input  wire logic [slpd_pkg::IndexWidth-1:0] csr_index,
   input  wire logic [slpd_pkg::DataWidth-1:0]  csr_data,
   output slpd_pkg::cfg_type                    cfg
);
   import slpd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            REG_PULSE_MIN:     cfg_in.pulse_min_ms     = csr_data[ShortWidth-1:0];
            REG_PULSE_MAX:     cfg_in.pulse_max_ms     = csr_data[ShortWidth-1:0];
            REG_GAP_TIMEOUT:   cfg_in.gap_timeout_ms   = csr_data[ShortWidth-1:0];
            REG_SETTLE_WINDOW: cfg_in.settle_window_ms = csr_data[ShortWidth-1:0];
            REG_READY_HOLD:    cfg_in.ready_hold_ms    = csr_data[ShortWidth-1:0];
            REG_READY_TIMEOUT: cfg_in.ready_timeout_ms = csr_data[TimeWidth-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pulse_min_ms     <= RST_PULSE_MIN;
         cfg_ff.pulse_max_ms     <= RST_PULSE_MAX;
         cfg_ff.gap_timeout_ms   <= RST_GAP_TIMEOUT;
         cfg_ff.settle_window_ms <= RST_SETTLE_WINDOW;
         cfg_ff.ready_hold_ms    <= RST_READY_HOLD;
         cfg_ff.ready_timeout_ms <= RST_READY_TIMEOUT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// File: src/slpd_core.sv
// Edge tracking and state machine of the start-light detector.
// Depends on slpd_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module slpd_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           fire,
   input  wire logic                           level,
   input  wire logic [slpd_pkg::TimeWidth-1:0] now_ms,
   input  slpd_pkg::cfg_type                   cfg,
   output slpd_pkg::result_type                result
);
   import slpd_pkg::*;

   logic [StateWidth-1:0] state_ff, state_in;
   logic                  last_level_ff;
   logic [TimeWidth-1:0]  on_time_ff, off_time_ff, change_time_ff;

   logic                  on_edge, off_edge, changed;
   logic [TimeWidth-1:0]  since_on, since_off, off_after_change, since_change;
   logic [TimeWidth-1:0]  pulse_min, pulse_max, gap_timeout, settle_window, ready_hold;
   logic                  gap_bad, pulse_long, pattern_lost, ready_armed;

   assign on_edge  = last_level_ff & ~level;
   assign off_edge = ~last_level_ff & level;

   // All differences wrap modulo 2^32.
   assign since_on         = now_ms - on_time_ff;
   assign since_off        = now_ms - off_time_ff;
   assign since_change     = now_ms - change_time_ff;
   assign off_after_change = off_time_ff - change_time_ff;

   assign pulse_min     = {{(TimeWidth-ShortWidth){1'b0}}, cfg.pulse_min_ms};
   assign pulse_max     = {{(TimeWidth-ShortWidth){1'b0}}, cfg.pulse_max_ms};
   assign gap_timeout   = {{(TimeWidth-ShortWidth){1'b0}}, cfg.gap_timeout_ms};
   assign settle_window = {{(TimeWidth-ShortWidth){1'b0}}, cfg.settle_window_ms};
   assign ready_hold    = {{(TimeWidth-ShortWidth){1'b0}}, cfg.ready_hold_ms};

   // Idle rules; arming wins over every loss rule.
   assign gap_bad      = on_edge && (since_off < pulse_min || since_off > pulse_max);
   assign pulse_long   = off_edge && (since_on > pulse_max);
   assign pattern_lost = (since_off > gap_timeout) && (off_after_change <= settle_window);
   assign ready_armed  = level && (since_off >= ready_hold)
                         && (off_after_change > settle_window);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_UNKNOWN: begin
            if (off_edge && since_on > pulse_min && since_on < pulse_max) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            priority if (ready_armed) begin
               state_in = ST_READY;
            end else if (gap_bad || pulse_long || pattern_lost) begin
               state_in = ST_UNKNOWN;
            end else begin
               state_in = state_ff;
            end
         end
         ST_READY: begin
            priority if (on_edge) begin
               state_in = ST_START;
            end else if (since_change > cfg.ready_timeout_ms) begin
               state_in = ST_UNKNOWN;
            end else begin
               state_in = state_ff;
            end
         end
         ST_START: begin
            if (level) begin
               state_in = ST_UNKNOWN;
            end
         end
         default: state_in = ST_UNKNOWN;
      endcase
   end

   // Every transition lands in a different state, so a change is a differing code.
   assign changed = (state_in != state_ff);

   assign result.detector_state = state_in;
   assign result.prior_state    = state_ff;
   assign result.state_changed  = changed;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_UNKNOWN;
         last_level_ff  <= 1'b0;
         on_time_ff     <= '0;
         off_time_ff    <= '0;
         change_time_ff <= '0;
      end else if (fire) begin
         state_ff      <= state_in;
         last_level_ff <= level;
         if (changed) begin
            change_time_ff <= now_ms;
         end
         if (on_edge) begin
            on_time_ff <= now_ms;
         end
         if (off_edge) begin
            off_time_ff <= now_ms;
         end
      end
   end

   `SLPD_ASSERT(a_start_exit, clock, reset,
      (fire && state_ff == ST_START) |=> (state_ff == ST_START || state_ff == ST_UNKNOWN),
      "start state left for a state other than unknown")
   `SLPD_ASSERT(a_change_stamp, clock, reset,
      (fire && changed) |=> (change_time_ff == $past(now_ms)),
      "state change did not record its time")

endmodule
`default_nettype wire

// File: src/start_light_pattern_detector_top.sv
// Top level of the start-light pattern detector: input stage, core, result register.
// Depends on slpd_pkg, slpd_csr, slpd_core and assert_macros.svh.
//
// Usage: each request beat carries one sensor sample, req_light_level (0 means
// light on, 1 means dark) and its millisecond timestamp req_now_ms. Every
// request beat yields exactly one response beat with the state after the
// sample, the state before it and a flag that tells whether a transition
// happened. Beats come out in the order they went in.
// An accepted request beat waits in the input register; once the response register is
// free, the state machine decides and its result is captured in the response
// register. Throughput is one beat per cycle while the receiver does not stall;
// the edge-time and state registers close their loop as each beat is decided.
// When the receiver raises rsp_stall, the response register holds its beat, the
// input register can still take one more beat, and only then is req_stall
// raised. Synchronous reset returns the state machine to unknown, clears the
// edge and change times and the last level, reloads the configuration defaults
// and empties both pipeline registers. Configuration writes through the csr_
// port take effect on the next clock and should be made while no beat is in
// flight.
`default_nettype none
`include "assert_macros.svh"
module start_light_pattern_detector_top (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output      logic                            req_stall,
   input  wire logic                            req_light_level,
   input  wire logic [slpd_pkg::TimeWidth-1:0]  req_now_ms,
   output      logic                            rsp_valid,
   input  wire logic                            rsp_stall,
   output      logic [slpd_pkg::StateWidth-1:0] rsp_detector_state,
   output      logic [slpd_pkg::StateWidth-1:0] rsp_prior_state,
   output      logic                            rsp_state_changed,
   input  wire logic                            csr_write_enable,
   input  wire logic [slpd_pkg::IndexWidth-1:0] csr_index,
   input  wire logic [slpd_pkg::DataWidth-1:0]  csr_data
);
   import slpd_pkg::*;

   cfg_type              cfg;
   result_type           core_result;

   logic                 in_valid_ff, in_valid_in;
   logic                 in_level_ff;
   logic [TimeWidth-1:0] in_now_ff;
   logic                 out_valid_ff, out_valid_in;
   result_type           out_result_ff;

   logic                 req_fire, core_fire, out_free;

   // The response register is free when empty or when its beat leaves now.
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign core_fire = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_fire  = req_valid && !req_stall;

   assign in_valid_in  = req_fire || (in_valid_ff && !core_fire);
   assign out_valid_in = core_fire || (out_valid_ff && rsp_stall);

   slpd_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .cfg              (cfg)
   );

   slpd_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (core_fire),
      .level  (in_level_ff),
      .now_ms (in_now_ff),
      .cfg    (cfg),
      .result (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_level_ff <= req_light_level;
         in_now_ff   <= req_now_ms;
      end
      if (core_fire) begin
         out_result_ff <= core_result;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_detector_state = out_result_ff.detector_state;
   assign rsp_prior_state    = out_result_ff.prior_state;
   assign rsp_state_changed  = out_result_ff.state_changed;

   `SLPD_ASSERT(a_change_flag, clock, reset,
      out_valid_ff |-> (out_result_ff.state_changed
                        == (out_result_ff.detector_state != out_result_ff.prior_state)),
      "change flag disagrees with the reported states")
   `SLPD_ASSERT(a_core_to_out, clock, reset,
      core_fire |=> out_valid_ff,
      "decided beat did not reach the response register")
   `SLPD_ASSERT_ALWAYS(a_reset_empty, clock,
      $past(reset) |-> (!in_valid_ff && !out_valid_ff),
      "pipeline not empty after reset")

endmodule
`default_nettype wire

// File: test/tb_start_light_pattern_detector_top.sv
// Self-checking testbench for start_light_pattern_detector_top: blink sequences and noise,
// with random idling on both channels and register settings that include the extremes.
// Depends on slpd_pkg and the detector RTL only.
`timescale 1ns / 100ps

module tb_start_light_pattern_detector_top;
   import slpd_pkg::*;

   localparam int NUM_PHASES = 7;
   localparam int PHASE_BEATS = 148;
   // Longest stretch without any accepted beat before the run is declared hung.
   localparam int STALL_LIMIT = 1000;
   // Cycles allowed after the last response for anything stray to show up.
   localparam int SETTLE_CYCLES = 8;
   // Indexes past the last register; writes to them must change nothing.
   localparam logic [IndexWidth-1:0] REG_UNUSED_LO = 3'd6;
   localparam logic [IndexWidth-1:0] REG_UNUSED_HI = 3'd7;

   // Tracks the detector state machine, edge times and register settings, and holds
   // the state reports that the block still owes us, oldest first.
   class state_trace_board;
      cfg_type cfg;
      logic [StateWidth-1:0] fsm;
      logic last_level;
      logic [TimeWidth-1:0] on_time;
      logic [TimeWidth-1:0] off_time;
      logic [TimeWidth-1:0] change_time;
      result_type predicted_states[$];
      int failures;

      function new();
         cfg.pulse_min_ms = RST_PULSE_MIN;
         cfg.pulse_max_ms = RST_PULSE_MAX;
         cfg.gap_timeout_ms = RST_GAP_TIMEOUT;
         cfg.settle_window_ms = RST_SETTLE_WINDOW;
         cfg.ready_hold_ms = RST_READY_HOLD;
         cfg.ready_timeout_ms = RST_READY_TIMEOUT;
         fsm = ST_UNKNOWN;
         last_level = 1'b0;
         on_time = '0;
         off_time = '0;
         change_time = '0;
         failures = 0;
      endfunction

      function void set_register(logic [IndexWidth-1:0] index, logic [DataWidth-1:0] data);
         case (index)
            REG_PULSE_MIN: cfg.pulse_min_ms = data[ShortWidth-1:0];
            REG_PULSE_MAX: cfg.pulse_max_ms = data[ShortWidth-1:0];
            REG_GAP_TIMEOUT: cfg.gap_timeout_ms = data[ShortWidth-1:0];
            REG_SETTLE_WINDOW: cfg.settle_window_ms = data[ShortWidth-1:0];
            REG_READY_HOLD: cfg.ready_hold_ms = data[ShortWidth-1:0];
            REG_READY_TIMEOUT: cfg.ready_timeout_ms = data[TimeWidth-1:0];
            default: ;
         endcase
      endfunction

      // Advances the state machine by one accepted sample and queues the report it causes.
      function void take_sample(logic level, logic [TimeWidth-1:0] now);
         logic on_edge;
         logic off_edge;
         logic [TimeWidth-1:0] since_on;
         logic [TimeWidth-1:0] since_off;
         logic [TimeWidth-1:0] since_change;
         logic [TimeWidth-1:0] off_after_change;
         result_type r;
         on_edge = last_level && !level;
         off_edge = !last_level && level;
         since_on = now - on_time;
         since_off = now - off_time;
         since_change = now - change_time;
         off_after_change = off_time - change_time;
         r.prior_state = fsm;
         r.detector_state = fsm;
         r.state_changed = 1'b0;
         case (fsm)
            ST_UNKNOWN: begin
               if (off_edge && since_on > cfg.pulse_min_ms && since_on < cfg.pulse_max_ms) begin
                  r.detector_state = ST_IDLE;
                  r.state_changed = 1'b1;
               end
            end
            ST_IDLE: begin
               // All rules look at the old edge times; the last one that fires wins.
               if (on_edge &&
                   (since_off < cfg.pulse_min_ms || since_off > cfg.pulse_max_ms)) begin
                  r.detector_state = ST_UNKNOWN;
                  r.state_changed = 1'b1;
               end
               if (off_edge && since_on > cfg.pulse_max_ms) begin
                  r.detector_state = ST_UNKNOWN;
                  r.state_changed = 1'b1;
               end
               if (since_off > cfg.gap_timeout_ms &&
                   off_after_change <= cfg.settle_window_ms) begin
                  r.detector_state = ST_UNKNOWN;
                  r.state_changed = 1'b1;
               end
               if (level && since_off >= cfg.ready_hold_ms &&
                   off_after_change > cfg.settle_window_ms) begin
                  r.detector_state = ST_READY;
                  r.state_changed = 1'b1;
               end
            end
            ST_READY: begin
               if (on_edge) begin
                  r.detector_state = ST_START;
                  r.state_changed = 1'b1;
               end else if (since_change > cfg.ready_timeout_ms) begin
                  r.detector_state = ST_UNKNOWN;
                  r.state_changed = 1'b1;
               end
            end
            default: begin
               if (level) begin
                  r.detector_state = ST_UNKNOWN;
                  r.state_changed = 1'b1;
               end
            end
         endcase
         if (r.state_changed)
            change_time = now;
         fsm = r.detector_state;
         last_level = level;
         if (on_edge)
            on_time = now;
         if (off_edge)
            off_time = now;
         predicted_states.push_back(r);
      endfunction

      function void compare_beat(result_type got);
         result_type want;
         if (predicted_states.size() == 0) begin
            $error("response beat with no sample outstanding: detector_state %0d",
                   got.detector_state);
            failures++;
            return;
         end
         want = predicted_states.pop_front();
         if (got.detector_state !== want.detector_state) begin
            $error("detector_state: expected %0d, actual %0d",
                   want.detector_state, got.detector_state);
            failures++;
         end
         if (got.prior_state !== want.prior_state) begin
            $error("prior_state: expected %0d, actual %0d", want.prior_state, got.prior_state);
            failures++;
         end
         if (got.state_changed !== want.state_changed) begin
            $error("state_changed: expected %0d, actual %0d",
                   want.state_changed, got.state_changed);
            failures++;
         end
      endfunction

      function int pending();
         return predicted_states.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic req_light_level;
   logic [TimeWidth-1:0] req_now_ms;
   logic rsp_valid;
   logic rsp_stall;
   logic [StateWidth-1:0] rsp_detector_state;
   logic [StateWidth-1:0] rsp_prior_state;
   logic rsp_state_changed;
   logic csr_write_enable;
   logic [IndexWidth-1:0] csr_index;
   logic [DataWidth-1:0] csr_data;

   state_trace_board board = new();
   // Set during the final phase: neither side idles then.
   bit quiet;
   int beats_sent;
   int idle_cycles;
   // Sensor time of the next sample in the blink sequences; it wraps freely.
   logic [TimeWidth-1:0] sensor_ms;

   start_light_pattern_detector_top uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_light_level(req_light_level),
      .req_now_ms(req_now_ms),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_detector_state(rsp_detector_state),
      .rsp_prior_state(rsp_prior_state),
      .rsp_state_changed(rsp_state_changed),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // The receiver stalls in random bursts, separated by free stretches.
   initial begin
      rsp_stall = 1'b0;
      @(posedge clock);
      forever begin
         if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 24)) @(posedge clock);
      end
   end

   // Response monitor and watchdog. Both look at the values that were present just
   // before the edge, so they agree with the block on which beats were accepted.
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (rsp_valid && !rsp_stall)
            board.compare_beat(result_type'{detector_state: rsp_detector_state,
                                            prior_state: rsp_prior_state,
                                            state_changed: rsp_state_changed});
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // Sends one sample beat, sometimes after an idle burst, and returns at the edge that
   // accepted it. Valid stays high on return so that back-to-back beats have no gap.
   task automatic push_sample(input logic level, input logic [TimeWidth-1:0] now);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_light_level <= level;
      req_now_ms <= now;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.take_sample(level, now);
      beats_sent++;
   endtask

   // Stops sending and waits until every outstanding response has come back, so that
   // the block is idle afterwards.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [IndexWidth-1:0] index,
                                 input logic [DataWidth-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      @(posedge clock);
      board.set_register(index, data);
   endtask

   // Writes all six registers. The 16-bit ones get random upper bits, which must be ignored.
   task automatic configure(input logic [ShortWidth-1:0] pmin, input logic [ShortWidth-1:0] pmax,
                            input logic [ShortWidth-1:0] gap, input logic [ShortWidth-1:0] settle,
                            input logic [ShortWidth-1:0] hold, input logic [TimeWidth-1:0] tmo);
      write_register(REG_PULSE_MIN, ($urandom & 32'hFFFF_0000) | pmin);
      write_register(REG_PULSE_MAX, ($urandom & 32'hFFFF_0000) | pmax);
      write_register(REG_GAP_TIMEOUT, ($urandom & 32'hFFFF_0000) | gap);
      write_register(REG_SETTLE_WINDOW, ($urandom & 32'hFFFF_0000) | settle);
      write_register(REG_READY_HOLD, ($urandom & 32'hFFFF_0000) | hold);
      write_register(REG_READY_TIMEOUT, tmo);
      csr_write_enable <= 1'b0;
   endtask

   // Picks a pulse or gap width: on, just inside or just past one of the bounds of the
   // accepted window, or else anywhere inside it.
   function automatic logic [TimeWidth-1:0] pick_width();
      logic [TimeWidth-1:0] lo;
      logic [TimeWidth-1:0] hi;
      lo = board.cfg.pulse_min_ms;
      hi = board.cfg.pulse_max_ms;
      case ($urandom_range(0, 9))
         0: return lo - 1;
         1: return lo;
         2: return lo + 1;
         3: return hi - 1;
         4: return hi;
         5: return hi + 1;
         default: return $urandom_range(hi, lo);
      endcase
   endfunction

   // Holds one level for span ms: the first sample marks the level change and the
   // extra ones fall evenly inside the span.
   task automatic hold_level(input logic level, input logic [TimeWidth-1:0] span, input int extra);
      longint offset;
      push_sample(level, sensor_ms);
      for (int i = 1; i <= extra; i++) begin
         offset = (longint'(span) * i) / (extra + 1);
         push_sample(level, sensor_ms + offset[TimeWidth-1:0]);
      end
      sensor_ms += span;
   endtask

   // One start sequence: up to 20 blinks scaled to the settle window, steady dark
   // probed around the gap timeout and the arming time, then either a light-on trigger
   // or a wait past the ready timeout, with or without a light-on edge at its end.
   task automatic run_episode();
      int period;
      int blinks;
      logic [TimeWidth-1:0] dark_start;
      logic [TimeWidth-1:0] hold;
      logic [TimeWidth-1:0] tmo;
      period = int'(board.cfg.pulse_min_ms) + int'(board.cfg.pulse_max_ms) + 1;
      blinks = int'(board.cfg.settle_window_ms) / period + $urandom_range(1, 4);
      if (blinks > 20)
         blinks = 20;
      hold_level(1'b1, pick_width(), $urandom_range(0, 1));
      for (int i = 0; i < blinks; i++) begin
         hold_level(1'b0, pick_width(), $urandom_range(0, 2));
         if (i < blinks - 1)
            hold_level(1'b1, pick_width(), $urandom_range(0, 1));
      end
      dark_start = sensor_ms;
      hold = board.cfg.ready_hold_ms;
      push_sample(1'b1, dark_start);
      push_sample(1'b1, dark_start + board.cfg.gap_timeout_ms + $urandom_range(0, 1));
      push_sample(1'b1, dark_start + hold - $urandom_range(0, 1));
      push_sample(1'b1, dark_start + hold);
      push_sample(1'b1, dark_start + hold + $urandom_range(1, 50));
      sensor_ms = dark_start + hold + 60;
      tmo = board.cfg.ready_timeout_ms;
      case ($urandom_range(0, 3))
         0, 1: begin
            hold_level(1'b0, $urandom_range(1, 50), $urandom_range(0, 2));
            hold_level(1'b1, $urandom_range(1, 50), 1);
         end
         2: begin
            sensor_ms += tmo + $urandom_range(0, 1);
            hold_level(1'b1, 10, 1);
         end
         default: begin
            // Light-on edge after the timeout has run out: the edge must win.
            sensor_ms += tmo + 1;
            hold_level(1'b0, 10, 0);
            hold_level(1'b1, 10, 0);
         end
      endcase
   endtask

   // Short runs of unrelated samples, some with a completely random timestamp.
   task automatic noise_burst();
      repeat ($urandom_range(1, 6)) begin
         if ($urandom_range(0, 3) == 0)
            sensor_ms = $urandom;
         else
            sensor_ms += $urandom_range(0, 200);
         push_sample(1'($urandom_range(0, 1)), sensor_ms);
      end
   endtask

   initial begin
      logic [ShortWidth-1:0] pulse_lo;
      reset = 1'b1;
      req_valid = 1'b0;
      req_light_level = 1'b0;
      req_now_ms = '0;
      csr_write_enable = 1'b0;
      csr_index = REG_PULSE_MIN;
      csr_data = '0;
      quiet = 1'b0;
      beats_sent = 0;
      sensor_ms = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed start sequence with the reset settings. The first off edge measures
      // a pulse that wraps around zero, which must not count as a valid pulse.
      push_sample(1'b0, 32'd0);
      push_sample(1'b1, 32'hFFFF_FFFF);
      push_sample(1'b0, 32'd100);
      push_sample(1'b1, 32'd150);   // 50 ms pulse: unknown to idle
      push_sample(1'b0, 32'd200);
      push_sample(1'b1, 32'd250);
      push_sample(1'b0, 32'd300);
      push_sample(1'b1, 32'd360);   // pulse exactly at the upper bound
      push_sample(1'b0, 32'd400);   // gap exactly at the lower bound
      push_sample(1'b1, 32'd440);
      push_sample(1'b0, 32'd500);
      push_sample(1'b1, 32'd550);
      push_sample(1'b0, 32'd600);
      push_sample(1'b1, 32'd660);   // last off edge, past the settle window
      push_sample(1'b1, 32'd781);   // dark past the gap timeout, but settled: stays idle
      push_sample(1'b1, 32'd2659);  // one ms short of arming
      push_sample(1'b1, 32'd2660);  // armed: ready
      push_sample(1'b1, 32'd2700);
      push_sample(1'b0, 32'd2710);  // light-on edge: start
      push_sample(1'b0, 32'd2720);
      push_sample(1'b1, 32'd2730);  // dark again: back to unknown

      sensor_ms = $urandom;
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         if (phase > 0)
            wait_drained();
         case (phase)
            0: ;
            1: begin
               write_register(REG_UNUSED_LO, $urandom);
               write_register(REG_UNUSED_HI, $urandom);
               configure(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0);
            end
            2: configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
            3: configure(16'd0, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 32'hFFFF_FFFF);
            4: configure(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 32'd0);
            default: begin
               pulse_lo = 16'($urandom_range(0, 100));
               configure(pulse_lo, 16'(pulse_lo + $urandom_range(0, 100)),
                         16'($urandom_range(0, 400)),
                         16'($urandom_range(0, 800)), 16'($urandom_range(0, 3000)),
                         $urandom_range(0, 1) ? $urandom_range(0, 5000) : $urandom);
            end
         endcase
         quiet = (phase == NUM_PHASES - 1);
         while (beats_sent < (phase + 1) * PHASE_BEATS) begin
            if ($urandom_range(0, 4) == 0)
               noise_burst();
            else
               run_episode();
            // Now and then hold off until the block has answered everything.
            if (!quiet && $urandom_range(0, 7) == 0)
               wait_drained();
         end
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.failures == 0 && board.pending() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// File: sim.f
+incdir+src
src/slpd_pkg.sv
src/slpd_csr.sv
src/slpd_core.sv
src/start_light_pattern_detector_top.sv
test/tb_start_light_pattern_detector_top.sv
